### sv/pcc_pkg.sv
// pcc_pkg: constants, types and helper functions for the pair co-occurrence counter
// used by pcc_ram, pcc_seq and pair_cooccurrence_counter
`timescale 1ns / 1ps

package pcc_pkg;

  localparam int MAX_VALUE       = 45;
  localparam int PICKS           = 5;
  localparam int COUNT_BITS      = 16;
  localparam int NUM_PICK_FIELDS = 5;
  localparam int VAL_W           = 6;
  localparam int OUT_W           = 16;
  localparam int DEPTH           = MAX_VALUE * MAX_VALUE;
  localparam int ADDR_W          = $clog2(DEPTH);
  localparam int PI_W            = (PICKS > 1) ? $clog2(PICKS) : 1;
  localparam longint OUT_MAX     = (64'd1 << OUT_W) - 64'd1;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [VAL_W-1:0]      val_t;

  typedef struct packed {
    logic   we;
    logic   re;
    addr_t  addr;
    count_t wdata;
  } mem_req_t;

  function automatic logic value_ok(input val_t v);
    return (v != '0) && ({26'd0, v} <= 32'(MAX_VALUE));
  endfunction

  // row-major index of pair (a,b), both in 1..MAX_VALUE
  function automatic addr_t pair_addr(input val_t a, input val_t b);
    addr_t ra;
    addr_t rb;
    ra = ADDR_W'(a) - ADDR_W'(1);
    rb = ADDR_W'(b) - ADDR_W'(1);
    return ADDR_W'(ra * ADDR_W'(MAX_VALUE)) + rb;
  endfunction

  function automatic logic [OUT_W-1:0] out_sat(input count_t c);
    logic [63:0] ext;
    ext = 64'(c);
    return (ext > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(ext);
  endfunction

endpackage

### sv/pcc_ram.sv
// pcc_ram: single-port counter table, one access per cycle, registered read data
// depends on pcc_pkg
`timescale 1ns / 1ps

module pcc_ram
  import pcc_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output count_t   rdata
);

  count_t mem [DEPTH];
  count_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/pcc_seq.sv
// pcc_seq: sequencer for clearing, pair walk and reads, with the shared saturating incrementer
// depends on pcc_pkg; drives pcc_ram through a mem_req_t
`timescale 1ns / 1ps

module pcc_seq
  import pcc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_action,
  input  val_t             in_pick [NUM_PICK_FIELDS],
  input  val_t             in_query_first,
  input  val_t             in_query_second,
  output logic             out_valid,
  output logic [OUT_W-1:0] out_pair_count,
  output mem_req_t         mem_req,
  input  count_t           mem_rdata
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PAIR  = 3'd2;
  localparam logic [2:0] S_INC   = 3'd3;
  localparam logic [2:0] S_QRY   = 3'd4;

  localparam count_t COUNT_MAX = '1;

  logic [2:0]       state_r, state_nxt;
  addr_t            clr_r, clr_nxt;
  val_t             pick_r [PICKS];
  val_t             pick_nxt [PICKS];
  logic [PICKS-1:0] valid_r, valid_nxt;
  logic [PI_W-1:0]  i_r, i_nxt;
  logic [PI_W-1:0]  j_r, j_nxt;
  addr_t            addr_r, addr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_count_r, out_count_nxt;
  count_t           inc_val;
  logic             accept;
  logic             last_j;
  logic             last_i;

  assign accept = start && (state_r == S_IDLE);
  assign last_j = (j_r == PI_W'(PICKS - 1));
  assign last_i = (i_r == PI_W'(PICKS - 1));

  // shared saturating incrementer
  assign inc_val = (mem_rdata == COUNT_MAX) ? mem_rdata : mem_rdata + count_t'(1);

  always_comb begin
    logic [PICKS-1:0] dup;
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    pick_nxt      = pick_r;
    valid_nxt     = valid_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    addr_nxt      = addr_r;
    out_valid_nxt = 1'b0;
    out_count_nxt = out_count_r;
    mem_req       = '0;
    dup           = '0;
    case (state_r)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = clr_r;
        mem_req.wdata = '0;
        clr_nxt       = clr_r + addr_t'(1);
        if (clr_r == addr_t'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_action == ACT_ADD) begin
            for (int k = 0; k < PICKS; k++) begin
              for (int m = 0; m < k; m++) begin
                if (in_pick[m] == in_pick[k]) begin
                  dup[k] = 1'b1;
                end
              end
              pick_nxt[k]  = in_pick[k];
              valid_nxt[k] = value_ok(in_pick[k]) && !dup[k];
            end
            i_nxt     = '0;
            j_nxt     = '0;
            state_nxt = S_PAIR;
          end else if (value_ok(in_query_first) && value_ok(in_query_second)) begin
            mem_req.re   = 1'b1;
            mem_req.addr = pair_addr(in_query_first, in_query_second);
            state_nxt    = S_QRY;
          end else begin
            out_valid_nxt = 1'b1;
            out_count_nxt = '0;
          end
        end
      end
      S_PAIR: begin
        if (valid_r[i_r] && valid_r[j_r]) begin
          mem_req.re   = 1'b1;
          mem_req.addr = pair_addr(pick_r[i_r], pick_r[j_r]);
          addr_nxt     = pair_addr(pick_r[i_r], pick_r[j_r]);
          state_nxt    = S_INC;
        end else begin
          if (last_j) begin
            j_nxt = '0;
            if (last_i) begin
              state_nxt = S_IDLE;
            end else begin
              i_nxt = i_r + PI_W'(1);
            end
          end else begin
            j_nxt = j_r + PI_W'(1);
          end
        end
      end
      S_INC: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = addr_r;
        mem_req.wdata = inc_val;
        state_nxt     = S_PAIR;
        if (last_j) begin
          j_nxt = '0;
          if (last_i) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt = i_r + PI_W'(1);
          end
        end else begin
          j_nxt = j_r + PI_W'(1);
        end
      end
      S_QRY: begin
        out_valid_nxt = 1'b1;
        out_count_nxt = out_sat(mem_rdata);
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pick_r      <= pick_nxt;
    valid_r     <= valid_nxt;
    addr_r      <= addr_nxt;
    out_count_r <= out_count_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_pair_count = out_count_r;

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_QRY) |-> !mem_req.we)
    else $error("counter table written outside clear or increment");

  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.we || mem_req.re) |-> (32'(mem_req.addr) < DEPTH))
    else $error("counter table address out of range");

  a_accept_effect: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid))
    else $error("accepted word had no effect");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_IDLE || $past(state_r) == S_QRY))
    else $error("result strobe from wrong state");

  a_inc_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INC) |-> $past(mem_req.re))
    else $error("increment without prior read");

endmodule

### sv/pair_cooccurrence_counter.sv
// pair_cooccurrence_counter: top level, sequencer plus counter table
// Reads: an in-range read returns the registered table count via S_QRY, other reads a zero word.
// Add words: the sequencer walks PICKS*PICKS pair slots, a read in S_PAIR and a saturating write
// back in S_INC on the single table port per present pair, a skip in S_PAIR per empty slot.
// Other reads can be taken every cycle; in-range reads hold busy in S_QRY; results never stall.
// Reset: a clearing pass writes all 2025 counters, one per cycle, with busy high throughout.
`timescale 1ns / 1ps

module pair_cooccurrence_counter
  import pcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [5:0]  in_pick_0,
  input  logic [5:0]  in_pick_1,
  input  logic [5:0]  in_pick_2,
  input  logic [5:0]  in_pick_3,
  input  logic [5:0]  in_pick_4,
  input  logic [5:0]  in_query_first,
  input  logic [5:0]  in_query_second,
  output logic        out_valid,
  output logic [15:0] out_pair_count
);

  val_t     picks [NUM_PICK_FIELDS];
  mem_req_t mem_req;
  count_t   mem_rdata;

  assign picks[0] = in_pick_0;
  assign picks[1] = in_pick_1;
  assign picks[2] = in_pick_2;
  assign picks[3] = in_pick_3;
  assign picks[4] = in_pick_4;

  pcc_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_pick         (picks),
    .in_query_first  (in_query_first),
    .in_query_second (in_query_second),
    .out_valid       (out_valid),
    .out_pair_count  (out_pair_count),
    .mem_req         (mem_req),
    .mem_rdata       (mem_rdata)
  );

  pcc_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

### dv/pair_cooccurrence_counter_check.sv
// pair_cooccurrence_counter_check: watches the command and result words, keeps its own
// pair count table and compares every read result in order; depends on pcc_pkg
`timescale 1ns / 1ps

module pair_cooccurrence_counter_check
  import pcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_action,
  input  logic [5:0]  in_pick_0,
  input  logic [5:0]  in_pick_1,
  input  logic [5:0]  in_pick_2,
  input  logic [5:0]  in_pick_3,
  input  logic [5:0]  in_pick_4,
  input  logic [5:0]  in_query_first,
  input  logic [5:0]  in_query_second,
  input  logic        out_valid,
  input  logic [15:0] out_pair_count,
  output int          errors,
  output int          outstanding,
  output int          counts_checked
);

  count_t          tally [1:MAX_VALUE][1:MAX_VALUE];
  logic [OUT_W-1:0] expected_counts [$];

  function automatic logic in_span(input logic [5:0] v);
    return (v != 6'd0) && (int'(v) <= MAX_VALUE);
  endfunction

  task automatic tally_set(input logic [NUM_PICK_FIELDS-1:0][5:0] picks);
    logic [MAX_VALUE:1] present;
    present = '0;
    for (int i = 0; i < PICKS && i < NUM_PICK_FIELDS; i++) begin
      if (in_span(picks[i])) present[picks[i]] = 1'b1;
    end
    for (int a = 1; a <= MAX_VALUE; a++) begin
      for (int b = 1; b <= MAX_VALUE; b++) begin
        if (present[a] && present[b] && tally[a][b] != '1) tally[a][b] = tally[a][b] + 1'b1;
      end
    end
  endtask

  function automatic logic [OUT_W-1:0] read_count(input logic [5:0] qa, input logic [5:0] qb);
    longint c;
    if (!(in_span(qa) && in_span(qb))) return '0;
    c = longint'(tally[qa][qb]);
    return (c > longint'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(c);
  endfunction

  always @(posedge clk) begin : watch_words
    logic [OUT_W-1:0] want;
    if (!rst_n) begin
      for (int a = 1; a <= MAX_VALUE; a++) begin
        for (int b = 1; b <= MAX_VALUE; b++) tally[a][b] = '0;
      end
      expected_counts.delete();
      errors <= 0;
      counts_checked <= 0;
    end else begin
      if (out_valid) begin
        if (expected_counts.size() == 0) begin
          $display("%0t: result word with none pending, expected none, actual %0d",
                   $time, out_pair_count);
          errors <= errors + 1;
        end else begin
          want = expected_counts.pop_front();
          counts_checked <= counts_checked + 1;
          if (out_pair_count !== want) begin
            $display("%0t: pair_count mismatch, expected %0d, actual %0d",
                     $time, want, out_pair_count);
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy) begin
        if (in_action == ACT_READ)
          expected_counts.insert(expected_counts.size(),
                                 read_count(in_query_first, in_query_second));
        else
          tally_set({in_pick_4, in_pick_3, in_pick_2, in_pick_1, in_pick_0});
      end
    end
    outstanding <= expected_counts.size();
  end

endmodule

### dv/pair_cooccurrence_counter_test.sv
// pair_cooccurrence_counter_test: top of the testbench, drives add and read words with
// random gaps and gives the verdict; depends on pcc_pkg and pair_cooccurrence_counter_check
`timescale 1ns / 1ps

module pair_cooccurrence_counter_test;
  import pcc_pkg::*;

  localparam int STALL_LIMIT  = 20000;
  localparam int RANDOM_WORDS = 1080;
  localparam int CALM_TAIL    = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_action = ACT_ADD;
  logic [5:0]  in_pick_0 = '0;
  logic [5:0]  in_pick_1 = '0;
  logic [5:0]  in_pick_2 = '0;
  logic [5:0]  in_pick_3 = '0;
  logic [5:0]  in_pick_4 = '0;
  logic [5:0]  in_query_first = '0;
  logic [5:0]  in_query_second = '0;
  logic        out_valid;
  logic [15:0] out_pair_count;

  int errors;
  int outstanding;
  int counts_checked;
  int stall_cycles = 0;
  int adds_sent = 0;
  int reads_sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pair_cooccurrence_counter DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_pick_0       (in_pick_0),
    .in_pick_1       (in_pick_1),
    .in_pick_2       (in_pick_2),
    .in_pick_3       (in_pick_3),
    .in_pick_4       (in_pick_4),
    .in_query_first  (in_query_first),
    .in_query_second (in_query_second),
    .out_valid       (out_valid),
    .out_pair_count  (out_pair_count)
  );

  pair_cooccurrence_counter_check checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_pick_0       (in_pick_0),
    .in_pick_1       (in_pick_1),
    .in_pick_2       (in_pick_2),
    .in_pick_3       (in_pick_3),
    .in_pick_4       (in_pick_4),
    .in_query_first  (in_query_first),
    .in_query_second (in_query_second),
    .out_valid       (out_valid),
    .out_pair_count  (out_pair_count),
    .errors          (errors),
    .outstanding     (outstanding),
    .counts_checked  (counts_checked)
  );

  always @(posedge clk) begin
    if (start && !busy) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [5:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 6'($urandom_range(1, 6));
    if (r < 80) return 6'($urandom_range(1, MAX_VALUE));
    if (r < 90) return 6'($urandom_range(0, 63));
    if (r < 95) return 6'd0;
    return 6'($urandom_range(MAX_VALUE + 1, 63));
  endfunction

  function automatic logic [5:0] query_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 6'($urandom_range(1, 6));
    if (r < 90) return 6'($urandom_range(1, MAX_VALUE));
    return 6'($urandom_range(0, 63));
  endfunction

  task automatic send_word(input logic act, input logic [5:0] p0, input logic [5:0] p1,
                           input logic [5:0] p2, input logic [5:0] p3, input logic [5:0] p4,
                           input logic [5:0] qf, input logic [5:0] qs);
    start <= 1'b1;
    in_action <= act;
    in_pick_0 <= p0;
    in_pick_1 <= p1;
    in_pick_2 <= p2;
    in_pick_3 <= p3;
    in_pick_4 <= p4;
    in_query_first <= qf;
    in_query_second <= qs;
    do @(posedge clk); while (busy);
    if (act == ACT_READ) reads_sent++;
    else adds_sent++;
  endtask

  task automatic add_set(input logic [5:0] p0, input logic [5:0] p1, input logic [5:0] p2,
                         input logic [5:0] p3, input logic [5:0] p4);
    send_word(ACT_ADD, p0, p1, p2, p3, p4, 6'($urandom_range(0, 63)),
              6'($urandom_range(0, 63)));
  endtask

  task automatic read_pair(input logic [5:0] qf, input logic [5:0] qs);
    send_word(ACT_READ, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
              6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
              6'($urandom_range(0, 63)), qf, qs);
  endtask

  // start low, junk on the fields
  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    in_action <= 1'($urandom_range(0, 1));
    in_pick_0 <= 6'($urandom_range(0, 63));
    in_pick_1 <= 6'($urandom_range(0, 63));
    in_pick_2 <= 6'($urandom_range(0, 63));
    in_pick_3 <= 6'($urandom_range(0, 63));
    in_pick_4 <= 6'($urandom_range(0, 63));
    in_query_first <= 6'($urandom_range(0, 63));
    in_query_second <= 6'($urandom_range(0, 63));
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    read_pair(6'd1, 6'd1);
    read_pair(6'd45, 6'd45);
    add_set(6'd1, 6'd45, 6'd2, 6'd3, 6'd4);
    read_pair(6'd1, 6'd45);
    read_pair(6'd45, 6'd1);
    read_pair(6'd45, 6'd45);
    read_pair(6'd3, 6'd2);
    // repeated value
    add_set(6'd7, 6'd7, 6'd7, 6'd7, 6'd7);
    read_pair(6'd7, 6'd7);
    read_pair(6'd7, 6'd1);
    // nothing in range
    add_set(6'd0, 6'd46, 6'd63, 6'd0, 6'd62);
    read_pair(6'd0, 6'd1);
    read_pair(6'd1, 6'd0);
    read_pair(6'd46, 6'd46);
    read_pair(6'd63, 6'd63);
    read_pair(6'd63, 6'd1);
    add_set(6'd45, 6'd0, 6'd45, 6'd46, 6'd1);
    read_pair(6'd45, 6'd1);
    read_pair(6'd1, 6'd1);
    add_set(6'd42, 6'd21, 6'd63, 6'd1, 6'd42);
    read_pair(6'd21, 6'd42);
    read_pair(6'd0, 6'd0);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 2) begin
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
      end
      if ($urandom_range(0, 99) < 45)
        read_pair(query_value(), query_value());
      else
        add_set(pick_value(), pick_value(), pick_value(), pick_value(), pick_value());
      if (n < RANDOM_WORDS - CALM_TAIL && (n / 40) % 3 != 2 && $urandom_range(0, 3) == 0)
        pause_sender($urandom_range(1, 16));
    end

    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (64) @(posedge clk);

    $display("sent %0d add words and %0d read words, %0d pair counts compared",
             adds_sent, reads_sent, counts_checked);
    $display("picks and queries covered the full 6-bit range, out-of-range and repeats");
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
